@@ src/vertex_matrix_transform_top_assert.svh @@
// Assertion macros for the vertex transform checker.
// Uses the checker's clk and rst_n; no other dependencies.
`ifndef VERTEX_MATRIX_TRANSFORM_TOP_ASSERT_SVH
`define VERTEX_MATRIX_TRANSFORM_TOP_ASSERT_SVH

// same-cycle implication, off during reset
`define VMT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vmt assertion failed");

// next-cycle implication, off during reset
`define VMT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vmt assertion failed");

// next-cycle implication, always armed (reset behavior)
`define VMT_ASSERT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("vmt assertion failed");

`endif

@@ src/vmt_pkg.sv @@
// Shared types and constants for the vertex matrix transform.
// No dependencies.
package vmt_pkg;

  localparam int ACC_W     = 58;  // holds the sum at the smallest fraction width
  localparam int NUM_REGS  = 8;
  localparam int REG_IDX_W = 3;
  localparam int CFG_W     = 64;
  localparam int DIV_STEPS = 32;
  localparam int LANES     = 3;

  localparam logic [1:0] ACT_DIRECTION = 2'd1;
  localparam int         ACT_PROJ_BIT  = 1;

  localparam logic signed [31:0] SMAX = 32'sh7fffffff;
  localparam logic signed [31:0] SMIN = 32'sh80000000;

  localparam logic [NUM_REGS-1:0][CFG_W-1:0] CFG_RESET = {
    64'h0001_0000_0000_0000, 64'h0, 64'h0000_0000_0001_0000, 64'h0,
    64'h0, 64'h0001_0000_0000_0000, 64'h0, 64'h0000_0000_0001_0000
  };

  typedef struct packed {
    logic [1:0]         action;
    logic signed [31:0] in_x;
    logic signed [31:0] in_y;
    logic signed [31:0] in_z;
  } vmt_in_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               saturated;
    logic               divide_fault;
  } vmt_out_t;

  typedef struct packed {
    logic [1:0]                  action;
    logic [3:0][ACC_W-1:0]       acc;
  } vmt_sum_t;

  typedef struct packed {
    logic                        divide;
    logic                        fault;
    logic                        sat;
    logic [LANES-1:0]            neg;
    logic [LANES-1:0]            ovf;
    logic [ACC_W-1:0]            den;
    logic [LANES-1:0][ACC_W:0]   rem;
    logic [LANES-1:0][31:0]      qd;
  } vmt_div_t;

endpackage

@@ src/vertex_matrix_transform_top.sv @@
// Vertex transform by a 4x4 Q-format matrix: accepts one beat per clock while not stalled and
// returns one result beat per input beat, in order, after 3 multiply/sum stages, 2 prepare
// stages, 32 divider stages that each resolve one quotient bit and 1 output stage. The 32-stage
// restoring divider sets the latency; every mode takes the same path, so timing does not
// depend on the data. A stall on the output freezes the whole pipeline in place. The matrix
// registers are written through the cfg port and must only change while the pipe is empty.
module vertex_matrix_transform_top #(
  parameter int FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  vmt_pkg::vmt_in_t                  in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output vmt_pkg::vmt_out_t                 out_data,
  input  logic                              cfg_wr_en,
  input  logic [vmt_pkg::REG_IDX_W-1:0]     cfg_index,
  input  logic [vmt_pkg::CFG_W-1:0]         cfg_wdata
);

  logic [vmt_pkg::NUM_REGS-1:0][vmt_pkg::CFG_W-1:0] cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= vmt_pkg::CFG_RESET;
    end else if (cfg_wr_en) begin
      cfg_r[cfg_index] <= cfg_wdata;
    end
  end

  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  logic              sum_vld;
  vmt_pkg::vmt_sum_t sum_d;

  vmt_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_vld    (in_valid),
    .in_d      (in_data),
    .coef_regs (cfg_r),
    .out_vld   (sum_vld),
    .out_d     (sum_d)
  );

  logic              div_vld [vmt_pkg::DIV_STEPS+1];
  vmt_pkg::vmt_div_t div_d   [vmt_pkg::DIV_STEPS+1];

  vmt_prep #(.FRAC_BITS(FRAC_BITS)) u_prep (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (sum_vld),
    .in_d    (sum_d),
    .out_vld (div_vld[0]),
    .out_d   (div_d[0])
  );

  for (genvar s = 0; s < vmt_pkg::DIV_STEPS; s++) begin : g_div
    vmt_div_step u_step (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .in_vld  (div_vld[s]),
      .in_d    (div_d[s]),
      .out_vld (div_vld[s+1]),
      .out_d   (div_d[s+1])
    );
  end

  vmt_post u_post (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (div_vld[vmt_pkg::DIV_STEPS]),
    .in_d    (div_d[vmt_pkg::DIV_STEPS]),
    .out_vld (out_valid),
    .out_d   (out_data)
  );

endmodule

@@ src/vmt_mac.sv @@
// Multiply-accumulate front end: input register, 12 products, column sums.
// Depends on vmt_pkg.
module vmt_mac #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                              clk,
  input  logic                                              rst_n,
  input  logic                                              en,
  input  logic                                              in_vld,
  input  vmt_pkg::vmt_in_t                                  in_d,
  input  logic [vmt_pkg::NUM_REGS-1:0][vmt_pkg::CFG_W-1:0]  coef_regs,
  output logic                                              out_vld,
  output vmt_pkg::vmt_sum_t                                 out_d
);

  logic signed [31:0] m [4][4];

  for (genvar r = 0; r < 4; r++) begin : g_row
    for (genvar c = 0; c < 4; c++) begin : g_col
      localparam int RI = 2 * r + c / 2;
      if (c % 2 == 1) begin : g_hi
        assign m[r][c] = coef_regs[RI][63:32];
      end else begin : g_lo
        assign m[r][c] = coef_regs[RI][31:0];
      end
    end
  end

  // stage 1: input beat
  vmt_pkg::vmt_in_t vin_r;
  logic             vld1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
    end else if (en) begin
      vld1_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vin_r <= in_d;
    end
  end

  // stage 2: products
  logic signed [31:0] v [3];
  logic signed [63:0] prod_nxt [3][4];
  logic signed [63:0] prod_r [3][4];
  logic [1:0]         act2_r;
  logic               vld2_r;

  assign v[0] = vin_r.in_x;
  assign v[1] = vin_r.in_y;
  assign v[2] = vin_r.in_z;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 4; c++) begin
        prod_nxt[r][c] = 64'(v[r]) * 64'(m[r][c]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld2_r <= 1'b0;
    end else if (en) begin
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
      act2_r <= vin_r.action;
    end
  end

  // stage 3: floor-shifted products plus translation row (only its w entry for direction beats)
  vmt_pkg::vmt_sum_t sum_nxt;
  vmt_pkg::vmt_sum_t sum_r;
  logic              vld3_r;

  always_comb begin
    logic signed [vmt_pkg::ACC_W-1:0] s;
    sum_nxt.action = act2_r;
    for (int c = 0; c < 4; c++) begin
      s = '0;
      for (int r = 0; r < 3; r++) begin
        s = s + vmt_pkg::ACC_W'(prod_r[r][c] >>> FRAC_BITS);
      end
      if (act2_r != vmt_pkg::ACT_DIRECTION || c == 3) begin
        s = s + vmt_pkg::ACC_W'(m[3][c]);
      end
      sum_nxt.acc[c] = s;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld3_r <= 1'b0;
    end else if (en) begin
      vld3_r <= vld2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum_r <= sum_nxt;
    end
  end

  assign out_vld = vld3_r;
  assign out_d   = sum_r;

endmodule

@@ src/vmt_prep.sv @@
// Clamp for affine/direction beats; magnitudes, signs and overflow test
// for projective beats. Two register stages. Depends on vmt_pkg.
module vmt_prep #(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_vld,
  input  vmt_pkg::vmt_sum_t in_d,
  output logic              out_vld,
  output vmt_pkg::vmt_div_t out_d
);

  localparam logic signed [vmt_pkg::ACC_W-1:0] ACC_MAX = vmt_pkg::ACC_W'(vmt_pkg::SMAX);
  localparam logic signed [vmt_pkg::ACC_W-1:0] ACC_MIN = vmt_pkg::ACC_W'(vmt_pkg::SMIN);
  localparam int HI_SHIFT = 32 - FRAC_BITS;

  // stage 4
  logic                                 proj_nxt, fault_nxt, sat_nxt;
  logic [vmt_pkg::LANES-1:0][31:0]      clamp_nxt;
  logic [vmt_pkg::LANES-1:0][vmt_pkg::ACC_W-1:0] mag_nxt;
  logic [vmt_pkg::LANES-1:0]            neg_nxt;
  logic [vmt_pkg::ACC_W-1:0]            den_nxt;

  logic                                 proj_r, fault_r, sat_r, vld4_r;
  logic [vmt_pkg::LANES-1:0][31:0]      clamp_r;
  logic [vmt_pkg::LANES-1:0][vmt_pkg::ACC_W-1:0] mag_r;
  logic [vmt_pkg::LANES-1:0]            neg_r;
  logic [vmt_pkg::ACC_W-1:0]            den_r;

  always_comb begin
    logic signed [vmt_pkg::ACC_W-1:0] a;
    logic signed [vmt_pkg::ACC_W-1:0] w;
    w         = $signed(in_d.acc[3]);
    proj_nxt  = in_d.action[vmt_pkg::ACT_PROJ_BIT];
    fault_nxt = proj_nxt && (w == '0);
    den_nxt   = w[vmt_pkg::ACC_W-1] ? vmt_pkg::ACC_W'(-w) : w;
    sat_nxt   = 1'b0;
    for (int i = 0; i < vmt_pkg::LANES; i++) begin
      a          = $signed(in_d.acc[i]);
      neg_nxt[i] = a[vmt_pkg::ACC_W-1] ^ w[vmt_pkg::ACC_W-1];
      mag_nxt[i] = a[vmt_pkg::ACC_W-1] ? vmt_pkg::ACC_W'(-a) : a;
      if (a > ACC_MAX) begin
        clamp_nxt[i] = vmt_pkg::SMAX;
        sat_nxt      = 1'b1;
      end else if (a < ACC_MIN) begin
        clamp_nxt[i] = vmt_pkg::SMIN;
        sat_nxt      = 1'b1;
      end else begin
        clamp_nxt[i] = a[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld4_r <= 1'b0;
    end else if (en) begin
      vld4_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      proj_r  <= proj_nxt;
      fault_r <= fault_nxt;
      sat_r   <= sat_nxt;
      clamp_r <= clamp_nxt;
      mag_r   <= mag_nxt;
      neg_r   <= neg_nxt;
      den_r   <= den_nxt;
    end
  end

  // stage 5: the quotient fits 32 bits only if |num| >> (32-F) < |w|
  vmt_pkg::vmt_div_t div_nxt;
  vmt_pkg::vmt_div_t div_r;
  logic              vld5_r;

  always_comb begin
    logic [vmt_pkg::ACC_W-1:0] hi;
    div_nxt.divide = proj_r && !fault_r;
    div_nxt.fault  = fault_r;
    div_nxt.sat    = proj_r ? 1'b0 : sat_r;
    div_nxt.neg    = neg_r;
    div_nxt.den    = den_r;
    for (int i = 0; i < vmt_pkg::LANES; i++) begin
      hi                 = mag_r[i] >> HI_SHIFT;
      div_nxt.ovf[i]     = hi >= den_r;
      div_nxt.rem[i]     = {1'b0, hi};
      if (div_nxt.divide) begin
        div_nxt.qd[i] = 32'(mag_r[i] << FRAC_BITS);
      end else if (fault_r) begin
        div_nxt.qd[i] = '0;
      end else begin
        div_nxt.qd[i] = clamp_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld5_r <= 1'b0;
    end else if (en) begin
      vld5_r <= vld4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      div_r <= div_nxt;
    end
  end

  assign out_vld = vld5_r;
  assign out_d   = div_r;

endmodule

@@ src/vmt_div_step.sv @@
// One restoring-division stage: one quotient bit per lane, registered.
// Depends on vmt_pkg.
module vmt_div_step (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_vld,
  input  vmt_pkg::vmt_div_t in_d,
  output logic              out_vld,
  output vmt_pkg::vmt_div_t out_d
);

  vmt_pkg::vmt_div_t d_nxt;
  vmt_pkg::vmt_div_t d_r;
  logic              vld_r;

  // qd shifts dividend bits out at the top and quotient bits in at the bottom
  always_comb begin
    logic [vmt_pkg::ACC_W:0] rem2;
    logic                    ge;
    d_nxt = in_d;
    for (int i = 0; i < vmt_pkg::LANES; i++) begin
      rem2 = {in_d.rem[i][vmt_pkg::ACC_W-1:0], in_d.qd[i][31]};
      ge   = rem2 >= {1'b0, in_d.den};
      if (in_d.divide) begin
        d_nxt.rem[i] = ge ? rem2 - {1'b0, in_d.den} : rem2;
        d_nxt.qd[i]  = {in_d.qd[i][30:0], ge};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign out_vld = vld_r;
  assign out_d   = d_r;

endmodule

@@ src/vmt_post.sv @@
// Sign, floor rounding and saturation of quotients; output register.
// Depends on vmt_pkg.
module vmt_post (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_vld,
  input  vmt_pkg::vmt_div_t in_d,
  output logic              out_vld,
  output vmt_pkg::vmt_out_t out_d
);

  localparam logic [32:0] NEG_LIMIT = 33'h0_8000_0000;

  logic [vmt_pkg::LANES-1:0][31:0] res;
  logic                            sat_nxt;
  vmt_pkg::vmt_out_t               out_nxt;
  vmt_pkg::vmt_out_t               out_r;
  logic                            vld_r;

  always_comb begin
    logic [32:0] qc;
    sat_nxt = in_d.sat;
    for (int i = 0; i < vmt_pkg::LANES; i++) begin
      // negative quotient: floor is minus the ceiling of the magnitude
      qc = {1'b0, in_d.qd[i]} + 33'(|in_d.rem[i]);
      if (!in_d.divide) begin
        res[i] = in_d.qd[i];
      end else if (in_d.ovf[i]) begin
        res[i]  = in_d.neg[i] ? vmt_pkg::SMIN : vmt_pkg::SMAX;
        sat_nxt = 1'b1;
      end else if (in_d.neg[i]) begin
        if (qc > NEG_LIMIT) begin
          res[i]  = vmt_pkg::SMIN;
          sat_nxt = 1'b1;
        end else begin
          res[i] = 32'(-qc);
        end
      end else if (in_d.qd[i][31]) begin
        res[i]  = vmt_pkg::SMAX;
        sat_nxt = 1'b1;
      end else begin
        res[i] = in_d.qd[i];
      end
    end
    out_nxt.out_x        = res[0];
    out_nxt.out_y        = res[1];
    out_nxt.out_z        = res[2];
    out_nxt.saturated    = sat_nxt;
    out_nxt.divide_fault = in_d.fault;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= out_nxt;
    end
  end

  assign out_vld = vld_r;
  assign out_d   = out_r;

endmodule

@@ src/vmt_checker.sv @@
// Port-level checks for the vertex transform, bound to the top level.
// Depends on vmt_pkg and vertex_matrix_transform_top_assert.svh.
`include "vertex_matrix_transform_top_assert.svh"

module vmt_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input vmt_pkg::vmt_out_t out_data
);

  `VMT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

  `VMT_ASSERT_NOW(a_fault_zero, out_valid && out_data.divide_fault, out_data.out_x == 0 && out_data.out_y == 0 && out_data.out_z == 0 && !out_data.saturated)

  `VMT_ASSERT_NOW(a_ready_path, 1'b1, in_ready == (!out_valid || out_ready))

  `VMT_ASSERT_ALWAYS(a_reset_empty, !rst_n, !out_valid)

endmodule

bind vertex_matrix_transform_top vmt_checker u_vmt_checker (.*);

@@ bench/vmt_checker.sv @@
// Checker for the vertex matrix transform: snoops the cfg port and both channels,
// predicts each result beat in order and compares it. Depends on vmt_pkg.
`timescale 1ns / 100ps

module vmt_scoreboard #(
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  vmt_pkg::vmt_in_t              in_data,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  vmt_pkg::vmt_out_t             out_data,
  input  logic                          cfg_wr_en,
  input  logic [vmt_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [vmt_pkg::CFG_W-1:0]     cfg_wdata,
  output int                            pending,
  output int                            fail_count
);

  logic [vmt_pkg::CFG_W-1:0] matrix_regs [vmt_pkg::NUM_REGS];
  vmt_pkg::vmt_out_t         expected_q [$];
  int                        mismatches;

  assign fail_count = mismatches;

  function automatic longint signed coef_at(int row, int col);
    logic [vmt_pkg::CFG_W-1:0] word;
    word = matrix_regs[row * 2 + col / 2];
    if (col % 2) return longint'(signed'(word[63:32]));
    return longint'(signed'(word[31:0]));
  endfunction

  function automatic logic signed [31:0] clamp(logic signed [127:0] val, inout logic sat);
    if (val > 128'sd2147483647) begin
      sat = 1'b1;
      return vmt_pkg::SMAX;
    end
    if (val < -128'sd2147483648) begin
      sat = 1'b1;
      return vmt_pkg::SMIN;
    end
    return val[31:0];
  endfunction

  function automatic vmt_pkg::vmt_out_t transform(vmt_pkg::vmt_in_t beat);
    longint signed       vec [3];
    longint signed       acc [4];
    logic signed [127:0] num, den, quo, rem;
    logic signed [31:0]  res [3];
    logic                sat;
    vmt_pkg::vmt_out_t   o;
    vec[0] = beat.in_x;
    vec[1] = beat.in_y;
    vec[2] = beat.in_z;
    sat = 1'b0;
    o = '0;
    for (int c = 0; c < 4; c++) begin
      acc[c] = 0;
      for (int r = 0; r < 3; r++) acc[c] += (vec[r] * coef_at(r, c)) >>> FRAC_BITS;
      if (beat.action != vmt_pkg::ACT_DIRECTION || c == 3) acc[c] += coef_at(3, c);
    end
    if (beat.action[vmt_pkg::ACT_PROJ_BIT]) begin
      if (acc[3] == 0) begin
        o.divide_fault = 1'b1;
        return o;
      end
      den = acc[3];
      for (int c = 0; c < 3; c++) begin
        num = 128'(signed'(acc[c])) <<< FRAC_BITS;
        quo = num / den;
        rem = num % den;
        // truncating divide; step down to floor when signs differ
        if (rem != 0 && ((num < 0) != (den < 0))) quo = quo - 1;
        res[c] = clamp(quo, sat);
      end
    end else begin
      for (int c = 0; c < 3; c++) res[c] = clamp(128'(signed'(acc[c])), sat);
    end
    o.out_x = res[0];
    o.out_y = res[1];
    o.out_z = res[2];
    o.saturated = sat;
    return o;
  endfunction

  always @(posedge clk) begin
    vmt_pkg::vmt_out_t want;
    if (!rst_n) begin
      for (int i = 0; i < vmt_pkg::NUM_REGS; i++) matrix_regs[i] <= vmt_pkg::CFG_RESET[i];
      expected_q.delete();
      mismatches <= 0;
      pending    <= 0;
    end else begin
      if (in_valid && in_ready) expected_q.push_back(transform(in_data));
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          if (mismatches < 10) $display("unexpected result beat %p", out_data);
          mismatches <= mismatches + 1;
        end else begin
          want = expected_q.pop_front();
          if (want.out_x !== out_data.out_x || want.out_y !== out_data.out_y ||
              want.out_z !== out_data.out_z || want.saturated !== out_data.saturated ||
              want.divide_fault !== out_data.divide_fault) begin
            if (mismatches < 10)
              $display("mismatch: exp x=%0d y=%0d z=%0d s=%0b f=%0b, got %0d %0d %0d %0b %0b",
                       want.out_x, want.out_y, want.out_z, want.saturated, want.divide_fault,
                       out_data.out_x, out_data.out_y, out_data.out_z, out_data.saturated,
                       out_data.divide_fault);
            mismatches <= mismatches + 1;
          end
        end
      end
      pending <= expected_q.size();
      if (cfg_wr_en) matrix_regs[cfg_index] <= cfg_wdata;
    end
  end
endmodule

@@ bench/testbench.sv @@
// Top of the vertex matrix transform bench: clock, reset, matrix setups, vertex stimulus
// and the verdict. Depends on vmt_pkg, vmt_scoreboard and vertex_matrix_transform_top.
`timescale 1ns / 100ps

module testbench;

  localparam int PHASES = 12;
  localparam int RAND_PER_PHASE = 80;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  vmt_pkg::vmt_in_t              in_data = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  vmt_pkg::vmt_out_t             out_data;
  logic                          cfg_wr_en = 1'b0;
  logic [vmt_pkg::REG_IDX_W-1:0] cfg_index = '0;
  logic [vmt_pkg::CFG_W-1:0]     cfg_wdata = '0;
  int                            pending, fail_count;
  bit                            no_idle = 1'b0;
  int                            results_seen = 0;

  always #6 clk = ~clk;

  vertex_matrix_transform_top DUT (.*);
  vmt_scoreboard u_scoreboard (.*);

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  // wide spread of magnitudes so projective results often stay in range
  function automatic logic [31:0] rand_q();
    logic signed [31:0] raw;
    raw = $urandom;
    return raw >>> $urandom_range(0, 20);
  endfunction

  task automatic send_vertex(logic [1:0] act, logic [31:0] x, logic [31:0] y, logic [31:0] z);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{action: act, in_x: x, in_y: y, in_z: z};
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic load_matrix(int kind);
    logic [31:0] lo, hi;
    for (int i = 0; i < vmt_pkg::NUM_REGS; i++) begin
      case (kind)
        1: begin  // column 4 and M44 zero: every projective beat faults
          lo = (i == 0 || i == 5) ? 32'h0001_0000 : (i == 2 ? 32'h0 : rand_q());
          hi = (i == 2) ? 32'h0001_0000 : 32'h0;
          if (i % 2 == 0 && i != 2) hi = rand_q();
          if (i % 2 == 0) hi = (i == 2) ? 32'h0001_0000 : rand_q();
          else hi = 32'h0;
        end
        2: begin lo = 32'h7fff_ffff; hi = 32'h7fff_ffff; end
        3: begin lo = 32'h8000_0000; hi = 32'h8000_0000; end
        4: begin lo = $urandom; hi = $urandom; end
        5: begin  // small column 4 so w hits zero now and then
          lo = rand_q();
          hi = (i % 2) ? 32'($urandom_range(0, 2)) - 32'd1 : rand_q();
        end
        default: begin lo = rand_q(); hi = rand_q(); end
      endcase
      cfg_wr_en <= 1'b1;
      cfg_index <= i[vmt_pkg::REG_IDX_W-1:0];
      cfg_wdata <= {hi, lo};
      @(posedge clk);
    end
    cfg_wr_en <= 1'b0;
  endtask

  // result side: random stalls, one long hold-off to back up the pipe
  initial begin
    int gap;
    @(posedge rst_n);
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, 3);
      if (results_seen == 400) gap = 200;
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      results_seen++;
    end
  end

  initial begin
    logic [31:0] edges [4];
    edges = '{32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'h0001_0000};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int ph = 0; ph < PHASES; ph++) begin
      no_idle = (ph % 4 == 3);
      if (ph > 0) load_matrix(ph % 7);
      if (ph < 2) begin
        for (int a = 0; a < 4; a++) begin
          for (int e = 0; e < 4; e++) send_vertex(a[1:0], edges[e], edges[e], edges[e]);
          send_vertex(a[1:0], 32'h0001_0000, 32'hffff_ffff, 32'h0000_0001);
        end
      end
      for (int n = 0; n < RAND_PER_PHASE; n++)
        send_vertex(2'($urandom_range(0, 3)),
                    ($urandom_range(0, 7) == 0) ? $urandom : rand_q(),
                    ($urandom_range(0, 7) == 0) ? $urandom : rand_q(),
                    ($urandom_range(0, 7) == 0) ? $urandom : rand_q());
      drain();
    end
    repeat (50) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
+incdir+src
src/vmt_pkg.sv
src/vmt_mac.sv
src/vmt_prep.sv
src/vmt_div_step.sv
src/vmt_post.sv
src/vertex_matrix_transform_top.sv
src/vmt_checker.sv
bench/vmt_checker.sv
bench/testbench.sv
